FILE: rtl/core/wsm_pkg.sv
`default_nettype none

package wsm_pkg;

    // command and wheel formats
    localparam int CMD_W     = 16;
    localparam int FRAC_W    = CMD_W - 1;
    localparam int GAIN_W    = 16;
    localparam int GAIN_FRAC = 12;
    localparam int OUT_W     = 20;
    localparam int MAG_W     = CMD_W + 1;
    localparam int WHEEL_W   = CMD_W + 2;
    localparam int SQ_W      = 2 * CMD_W;
    localparam int Q_W       = CMD_W;
    localparam int NUM_W     = MAG_W + FRAC_W + 1;
    localparam int PROD_W    = Q_W + GAIN_W;
    localparam int RND_W     = PROD_W + 2 - GAIN_FRAC;
    localparam int NUM_LANES = 4;

    // unity in wheel format
    localparam logic [MAG_W-1:0] ONE_MAG = MAG_W'(1) << FRAC_W;

    // configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_ENABLED = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TRACTION_MODE = CFG_IDX_W'(1);

    // pipeline stage positions
    localparam int ST_IN    = 0;
    localparam int ST_SQ    = 1;
    localparam int ST_WHEEL = 2;
    localparam int ST_PEAK  = 3;
    localparam int ST_DIV0  = 4;
    localparam int ST_PROD  = ST_DIV0 + Q_W;
    localparam int ST_OUT   = ST_PROD + 1;
    localparam int NSTAGE   = ST_OUT + 1;

    typedef logic signed [WHEEL_W-1:0] t_wheel;
    typedef logic signed [CMD_W-1:0]   t_cmd;
    typedef logic signed [OUT_W-1:0]   t_set;

    // stage load enables plus the mixing mode
    typedef struct packed {
        logic [NSTAGE-1:0] en;
        logic              traction;
    } t_pipe_ctl;

    function automatic t_wheel wsm_max(input t_wheel a, input t_wheel b);
        return (a > b) ? a : b;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/wsm_mix.sv
`default_nettype none

module wsm_mix (
    input  wire logic                  i_clk,
    input  wire wsm_pkg::t_pipe_ctl    i_ctl,
    input  wire wsm_pkg::t_cmd         i_x,
    input  wire wsm_pkg::t_cmd         i_y,
    input  wire wsm_pkg::t_cmd         i_r,
    input  wire logic [wsm_pkg::GAIN_W-1:0] i_gain,
    output wsm_pkg::t_wheel            o_w [wsm_pkg::NUM_LANES],
    output logic [wsm_pkg::GAIN_W-1:0] o_gain
);

    // input stage
    wsm_pkg::t_cmd r_in_x, r_in_y, r_in_r;
    logic [wsm_pkg::GAIN_W-1:0] r_in_gain;
    logic r_in_mode;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[wsm_pkg::ST_IN]) begin
            r_in_x    <= i_x;
            r_in_y    <= i_y;
            r_in_r    <= i_r;
            r_in_gain <= i_gain;
            r_in_mode <= i_ctl.traction;
        end
    end

    // magnitude squares
    logic [wsm_pkg::CMD_W-1:0] xmag, rmag;
    logic [wsm_pkg::SQ_W-1:0]  n_sq_x2, n_sq_r2;

    always_comb begin
        xmag    = r_in_x[wsm_pkg::CMD_W-1] ? (~r_in_x + 1'b1) : r_in_x;
        rmag    = r_in_r[wsm_pkg::CMD_W-1] ? (~r_in_r + 1'b1) : r_in_r;
        n_sq_x2 = xmag * xmag;
        n_sq_r2 = rmag * rmag;
    end

    logic [wsm_pkg::SQ_W-1:0] r_sq_x2, r_sq_r2;
    wsm_pkg::t_cmd r_sq_x, r_sq_y, r_sq_r;
    logic [wsm_pkg::GAIN_W-1:0] r_sq_gain;
    logic r_sq_mode;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[wsm_pkg::ST_SQ]) begin
            r_sq_x2   <= n_sq_x2;
            r_sq_r2   <= n_sq_r2;
            r_sq_x    <= r_in_x;
            r_sq_y    <= r_in_y;
            r_sq_r    <= r_in_r;
            r_sq_gain <= r_in_gain;
            r_sq_mode <= r_in_mode;
        end
    end

    // wheel mixing
    wsm_pkg::t_wheel n_w [wsm_pkg::NUM_LANES];
    logic [wsm_pkg::SQ_W-1:0] xs_rnd, rs_rnd;
    wsm_pkg::t_wheel mv, rv, left, right, xe, ye, re;

    always_comb begin
        xs_rnd = r_sq_x2 + (wsm_pkg::SQ_W'(1) << (wsm_pkg::FRAC_W - 1));
        rs_rnd = r_sq_r2 + (wsm_pkg::SQ_W'(1) << (wsm_pkg::FRAC_W - 1));
        mv = wsm_pkg::t_wheel'(xs_rnd >> wsm_pkg::FRAC_W);
        rv = wsm_pkg::t_wheel'(rs_rnd >> wsm_pkg::FRAC_W);
        if (r_sq_x[wsm_pkg::CMD_W-1]) mv = -mv;
        if (r_sq_r[wsm_pkg::CMD_W-1]) rv = -rv;
        if (mv > 0) begin
            if (rv > 0) begin
                left  = mv - rv;
                right = wsm_pkg::wsm_max(mv, rv);
            end else begin
                left  = wsm_pkg::wsm_max(mv, -rv);
                right = mv + rv;
            end
        end else begin
            if (rv > 0) begin
                left  = -wsm_pkg::wsm_max(-mv, rv);
                right = mv + rv;
            end else begin
                left  = mv - rv;
                right = -wsm_pkg::wsm_max(-mv, -rv);
            end
        end
        xe = wsm_pkg::t_wheel'(r_sq_x);
        ye = wsm_pkg::t_wheel'(r_sq_y);
        re = wsm_pkg::t_wheel'(r_sq_r);
        if (r_sq_mode) begin
            n_w[0] = -xe + ye + re;
            n_w[1] =  xe + ye - re;
            n_w[2] =  xe + ye + re;
            n_w[3] = -xe + ye - re;
        end else begin
            n_w[0] = left;
            n_w[1] = left;
            n_w[2] = right;
            n_w[3] = right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[wsm_pkg::ST_WHEEL]) begin
            o_w    <= n_w;
            o_gain <= r_sq_gain;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/wsm_norm.sv
`default_nettype none

module wsm_norm (
    input  wire logic                  i_clk,
    input  wire wsm_pkg::t_pipe_ctl    i_ctl,
    input  wire wsm_pkg::t_wheel       i_w [wsm_pkg::NUM_LANES],
    input  wire logic [wsm_pkg::GAIN_W-1:0] i_gain,
    output logic [wsm_pkg::Q_W-1:0]    o_q [wsm_pkg::NUM_LANES],
    output logic [wsm_pkg::NUM_LANES-1:0] o_neg,
    output logic [wsm_pkg::GAIN_W-1:0] o_gain
);

    // magnitudes and peak; divisor is the peak or unity
    logic [wsm_pkg::MAG_W-1:0] mag [wsm_pkg::NUM_LANES];
    logic [wsm_pkg::MAG_W-1:0] pk01, pk23, peak, n_dsr;
    wsm_pkg::t_wheel           tmp;

    always_comb begin
        for (int k = 0; k < wsm_pkg::NUM_LANES; k++) begin
            tmp    = (i_w[k] < 0) ? -i_w[k] : i_w[k];
            mag[k] = tmp[wsm_pkg::MAG_W-1:0];
        end
        pk01  = (mag[0] > mag[1]) ? mag[0] : mag[1];
        pk23  = (mag[2] > mag[3]) ? mag[2] : mag[3];
        peak  = (pk01 > pk23) ? pk01 : pk23;
        n_dsr = (peak > wsm_pkg::ONE_MAG) ? peak : wsm_pkg::ONE_MAG;
    end

    logic [wsm_pkg::MAG_W-1:0] r_pk_mag [wsm_pkg::NUM_LANES];
    logic [wsm_pkg::NUM_LANES-1:0] r_pk_neg;
    logic [wsm_pkg::MAG_W-1:0] r_pk_dsr;
    logic [wsm_pkg::GAIN_W-1:0] r_pk_gain;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[wsm_pkg::ST_PEAK]) begin
            r_pk_mag  <= mag;
            r_pk_dsr  <= n_dsr;
            r_pk_gain <= i_gain;
            for (int k = 0; k < wsm_pkg::NUM_LANES; k++) begin
                r_pk_neg[k] <= i_w[k][wsm_pkg::WHEEL_W-1];
            end
        end
    end

    // restoring divider, one quotient bit per stage; lo shifts out the
    // low numerator bits and shifts in the quotient
    logic [wsm_pkg::MAG_W-1:0] r_dv_rem [wsm_pkg::Q_W][wsm_pkg::NUM_LANES];
    logic [wsm_pkg::Q_W-1:0]   r_dv_lo  [wsm_pkg::Q_W][wsm_pkg::NUM_LANES];
    logic [wsm_pkg::MAG_W-1:0] r_dv_dsr [wsm_pkg::Q_W];
    logic [wsm_pkg::NUM_LANES-1:0] r_dv_neg [wsm_pkg::Q_W];
    logic [wsm_pkg::GAIN_W-1:0] r_dv_gain [wsm_pkg::Q_W];

    logic [wsm_pkg::MAG_W-1:0] n_dv_rem [wsm_pkg::Q_W][wsm_pkg::NUM_LANES];
    logic [wsm_pkg::Q_W-1:0]   n_dv_lo  [wsm_pkg::Q_W][wsm_pkg::NUM_LANES];
    logic [wsm_pkg::NUM_W-1:0] num;
    logic [wsm_pkg::MAG_W-1:0] rem_in, dsr_in;
    logic [wsm_pkg::Q_W-1:0]   lo_in;
    logic [wsm_pkg::MAG_W:0]   trial;
    logic                      ge;

    always_comb begin
        for (int s = 0; s < wsm_pkg::Q_W; s++) begin
            for (int k = 0; k < wsm_pkg::NUM_LANES; k++) begin
                if (s == 0) begin
                    num = ({1'b0, r_pk_mag[k], wsm_pkg::FRAC_W'(0)})
                        + wsm_pkg::NUM_W'(r_pk_dsr >> 1);
                    rem_in = num[wsm_pkg::NUM_W-1:wsm_pkg::Q_W];
                    lo_in  = num[wsm_pkg::Q_W-1:0];
                    dsr_in = r_pk_dsr;
                end else begin
                    rem_in = r_dv_rem[s-1][k];
                    lo_in  = r_dv_lo[s-1][k];
                    dsr_in = r_dv_dsr[s-1];
                end
                trial = {rem_in, lo_in[wsm_pkg::Q_W-1]};
                ge    = (trial >= {1'b0, dsr_in});
                if (ge) begin
                    trial = trial - {1'b0, dsr_in};
                end
                n_dv_rem[s][k] = trial[wsm_pkg::MAG_W-1:0];
                n_dv_lo[s][k]  = {lo_in[wsm_pkg::Q_W-2:0], ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < wsm_pkg::Q_W; s++) begin
            if (i_ctl.en[wsm_pkg::ST_DIV0 + s]) begin
                r_dv_rem[s] <= n_dv_rem[s];
                r_dv_lo[s]  <= n_dv_lo[s];
                if (s == 0) begin
                    r_dv_dsr[s]  <= r_pk_dsr;
                    r_dv_neg[s]  <= r_pk_neg;
                    r_dv_gain[s] <= r_pk_gain;
                end else begin
                    r_dv_dsr[s]  <= r_dv_dsr[s-1];
                    r_dv_neg[s]  <= r_dv_neg[s-1];
                    r_dv_gain[s] <= r_dv_gain[s-1];
                end
            end
        end
    end

    assign o_q    = r_dv_lo[wsm_pkg::Q_W-1];
    assign o_neg  = r_dv_neg[wsm_pkg::Q_W-1];
    assign o_gain = r_dv_gain[wsm_pkg::Q_W-1];

endmodule

`default_nettype wire

FILE: rtl/core/wsm_out.sv
`default_nettype none

module wsm_out (
    input  wire logic                  i_clk,
    input  wire wsm_pkg::t_pipe_ctl    i_ctl,
    input  wire logic [wsm_pkg::Q_W-1:0] i_q [wsm_pkg::NUM_LANES],
    input  wire logic [wsm_pkg::NUM_LANES-1:0] i_neg,
    input  wire logic [wsm_pkg::GAIN_W-1:0] i_gain,
    output wsm_pkg::t_set              o_set [wsm_pkg::NUM_LANES]
);

    // gain product
    logic [wsm_pkg::PROD_W-1:0] r_pr_prod [wsm_pkg::NUM_LANES];
    logic [wsm_pkg::NUM_LANES-1:0] r_pr_neg;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[wsm_pkg::ST_PROD]) begin
            for (int k = 0; k < wsm_pkg::NUM_LANES; k++) begin
                r_pr_prod[k] <= i_q[k] * i_gain;
            end
            r_pr_neg <= i_neg;
        end
    end

    // round, apply sign, negate left wheels, saturate
    localparam logic signed [wsm_pkg::RND_W-1:0] SAT_HI =
        wsm_pkg::RND_W'((1 << (wsm_pkg::OUT_W - 1)) - 1);
    localparam logic signed [wsm_pkg::RND_W-1:0] SAT_LO = -SAT_HI - 1;

    wsm_pkg::t_set n_set [wsm_pkg::NUM_LANES];
    logic [wsm_pkg::PROD_W:0]           rsum;
    logic signed [wsm_pkg::RND_W-1:0]   val;
    logic                               flip;

    always_comb begin
        for (int k = 0; k < wsm_pkg::NUM_LANES; k++) begin
            rsum = {1'b0, r_pr_prod[k]}
                 + ((wsm_pkg::PROD_W + 1)'(1) << (wsm_pkg::GAIN_FRAC - 1));
            val  = wsm_pkg::RND_W'(rsum >> wsm_pkg::GAIN_FRAC);
            flip = (k < 2) ? !r_pr_neg[k] : r_pr_neg[k];
            if (flip) val = -val;
            if (val > SAT_HI) val = SAT_HI;
            if (val < SAT_LO) val = SAT_LO;
            n_set[k] = val[wsm_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[wsm_pkg::ST_OUT]) begin
            o_set <= n_set;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/wheel_speed_mixer.sv
`default_nettype none

// Four-wheel setpoint mixer. Each accepted command word (x, y, rotation,
// gain) yields one setpoint word while drive_enabled is 1 and nothing while
// it is 0. The pipeline is 22 stages deep, and a new command word is taken
// every cycle while the output is not stalled; the depth is set by the
// normalizing divider, which resolves one quotient bit per stage.
// Configuration writes (index 0 drive_enabled, index 1 traction_mode) are
// always ready.
module wheel_speed_mixer (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic signed [wsm_pkg::CMD_W-1:0] i_x_cmd,
    input  wire logic signed [wsm_pkg::CMD_W-1:0] i_y_cmd,
    input  wire logic signed [wsm_pkg::CMD_W-1:0] i_rot_cmd,
    input  wire logic [wsm_pkg::GAIN_W-1:0]       i_output_scale,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic signed [wsm_pkg::OUT_W-1:0]      o_front_left_set,
    output logic signed [wsm_pkg::OUT_W-1:0]      o_rear_left_set,
    output logic signed [wsm_pkg::OUT_W-1:0]      o_front_right_set,
    output logic signed [wsm_pkg::OUT_W-1:0]      o_rear_right_set,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [wsm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic                     i_cfg_data
);

    // configuration registers
    logic r_drive_enabled, r_traction_mode;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive_enabled <= 1'b0;
            r_traction_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == wsm_pkg::REG_DRIVE_ENABLED) begin
                r_drive_enabled <= i_cfg_data;
            end else if (i_cfg_index == wsm_pkg::REG_TRACTION_MODE) begin
                r_traction_mode <= i_cfg_data;
            end
        end
    end

    // stage valids and load enables; a stage loads when empty or draining
    logic [wsm_pkg::NSTAGE-1:0] r_v, en;
    wsm_pkg::t_pipe_ctl ctl;

    always_comb begin
        en[wsm_pkg::NSTAGE-1] = !r_v[wsm_pkg::NSTAGE-1] || !i_out_stall;
        for (int s = wsm_pkg::NSTAGE - 2; s >= 0; s--) begin
            en[s] = !r_v[s] || en[s+1];
        end
        ctl.en       = en;
        ctl.traction = r_traction_mode;
    end

    assign o_in_stall  = !en[0];
    assign o_out_valid = r_v[wsm_pkg::NSTAGE-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int s = 0; s < wsm_pkg::NSTAGE; s++) begin
                if (en[s]) begin
                    r_v[s] <= (s == 0) ? (i_in_valid && r_drive_enabled) : r_v[s-1];
                end
            end
        end
    end

    // datapath
    wsm_pkg::t_wheel w [wsm_pkg::NUM_LANES];
    logic [wsm_pkg::GAIN_W-1:0] mix_gain, norm_gain;
    logic [wsm_pkg::Q_W-1:0] q [wsm_pkg::NUM_LANES];
    logic [wsm_pkg::NUM_LANES-1:0] neg;
    wsm_pkg::t_set set [wsm_pkg::NUM_LANES];

    wsm_mix u_mix (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_x    (i_x_cmd),
        .i_y    (i_y_cmd),
        .i_r    (i_rot_cmd),
        .i_gain (i_output_scale),
        .o_w    (w),
        .o_gain (mix_gain)
    );

    wsm_norm u_norm (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_w    (w),
        .i_gain (mix_gain),
        .o_q    (q),
        .o_neg  (neg),
        .o_gain (norm_gain)
    );

    wsm_out u_out (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_q    (q),
        .i_neg  (neg),
        .i_gain (norm_gain),
        .o_set  (set)
    );

    assign o_front_left_set  = set[0];
    assign o_rear_left_set   = set[1];
    assign o_front_right_set = set[2];
    assign o_rear_right_set  = set[3];

endmodule

`default_nettype wire

FILE: rtl/core/wsm_checker.sv
`default_nettype none

module wsm_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire logic signed [19:0] o_front_left_set,
    input wire logic               o_cfg_ready
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("word out right after reset");

    // input backs up only behind a stalled output word
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled with output free");

    // config port never blocks
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config port not ready");

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_front_left_set)))
        else $error("stalled output word changed");

endmodule

bind wheel_speed_mixer wsm_checker u_wsm_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_front_left_set (o_front_left_set),
    .o_cfg_ready      (o_cfg_ready)
);

`default_nettype wire

FILE: test/wheel_speed_mixer_test.sv
`default_nettype none

module wheel_speed_mixer_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_DEPTH = 22;
    localparam int FRAC = 15;
    localparam longint ONE = 64'sd1 << FRAC;
    // an index that names no register
    localparam logic [wsm_pkg::CFG_IDX_W-1:0] REG_UNUSED = wsm_pkg::CFG_IDX_W'(7);

    typedef struct packed {
        logic signed [19:0] fl;
        logic signed [19:0] rl;
        logic signed [19:0] fr;
        logic signed [19:0] rr;
    } t_setpoints;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic signed [15:0] i_x_cmd = '0;
    logic signed [15:0] i_y_cmd = '0;
    logic signed [15:0] i_rot_cmd = '0;
    logic [15:0] i_output_scale = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [19:0] o_front_left_set, o_rear_left_set;
    logic signed [19:0] o_front_right_set, o_rear_right_set;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [wsm_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic i_cfg_data = 1'b0;

    // model copy of the registers
    bit drive_on;
    bit mecanum_on;

    t_setpoints setpoint_queue[$];
    int mismatches;
    int words_sent;
    int words_checked;
    int mecanum_words;
    int arcade_words;
    bit burst_mode;

    wheel_speed_mixer i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_x_cmd(i_x_cmd), .i_y_cmd(i_y_cmd), .i_rot_cmd(i_rot_cmd),
        .i_output_scale(i_output_scale),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_front_left_set(o_front_left_set), .o_rear_left_set(o_rear_left_set),
        .o_front_right_set(o_front_right_set), .o_rear_right_set(o_rear_right_set),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #50ms;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic longint abs64(longint v);
        return v < 0 ? -v : v;
    endfunction

    // round to nearest on magnitude, ties away from zero
    function automatic longint round_shift(longint v, int sh);
        longint m;
        m = (abs64(v) + (64'sd1 << (sh - 1))) >>> sh;
        return v < 0 ? -m : m;
    endfunction

    function automatic longint square_keep_sign(longint v);
        longint m;
        m = (abs64(v) * abs64(v) + (64'sd1 << (FRAC - 1))) >>> FRAC;
        return v < 0 ? -m : m;
    endfunction

    function automatic longint max64(longint a, longint b);
        return a > b ? a : b;
    endfunction

    function automatic logic signed [19:0] clamp20(longint v);
        if (v > 524287) v = 524287;
        if (v < -524288) v = -524288;
        return v[19:0];
    endfunction

    // wheel mix, normalize, gain and saturate
    function automatic t_setpoints mix_wheels(logic signed [15:0] x, logic signed [15:0] y,
                                              logic signed [15:0] r, logic [15:0] gain,
                                              bit mecanum);
        longint w[4];
        longint xv, yv, rv, mv, sv, lft, rgt, peak, m, s;
        logic signed [19:0] o[4];
        t_setpoints res;
        xv = x; yv = y; rv = r;
        if (mecanum) begin
            w[0] = -xv + yv + rv;
            w[2] = xv + yv + rv;
            w[1] = xv + yv - rv;
            w[3] = -xv + yv - rv;
        end else begin
            mv = square_keep_sign(xv);
            sv = square_keep_sign(rv);
            if (mv > 0) begin
                if (sv > 0) begin
                    lft = mv - sv; rgt = max64(mv, sv);
                end else begin
                    lft = max64(mv, -sv); rgt = mv + sv;
                end
            end else begin
                if (sv > 0) begin
                    lft = -max64(-mv, sv); rgt = mv + sv;
                end else begin
                    lft = mv - sv; rgt = -max64(-mv, -sv);
                end
            end
            w[0] = lft; w[1] = lft; w[2] = rgt; w[3] = rgt;
        end
        peak = 0;
        for (int k = 0; k < 4; k++) peak = max64(peak, abs64(w[k]));
        if (peak > ONE) begin
            for (int k = 0; k < 4; k++) begin
                m = (abs64(w[k]) * ONE + peak / 2) / peak;
                w[k] = w[k] < 0 ? -m : m;
            end
        end
        for (int k = 0; k < 4; k++) begin
            s = round_shift(w[k] * longint'(gain), wsm_pkg::GAIN_FRAC);
            if (k < 2) s = -s;
            o[k] = clamp20(s);
        end
        res.fl = o[0]; res.rl = o[1]; res.fr = o[2]; res.rr = o[3];
        return res;
    endfunction

    // receiver stall pattern
    initial begin
        int mode;
        forever begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(20, 200)) begin
                @(negedge i_clk);
                case (mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(0, 3) == 0);
                    2: i_out_stall <= ($urandom_range(0, 1) == 0);
                    default: i_out_stall <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_setpoints got, want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.fl = o_front_left_set; got.rl = o_rear_left_set;
            got.fr = o_front_right_set; got.rr = o_rear_right_set;
            words_checked++;
            if (setpoint_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected setpoint word fl=%0d rl=%0d fr=%0d rr=%0d",
                             got.fl, got.rl, got.fr, got.rr);
            end else begin
                want = setpoint_queue.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: fl %0d/%0d rl %0d/%0d fr %0d/%0d rr %0d/%0d",
                                 want.fl, got.fl, want.rl, got.rl,
                                 want.fr, got.fr, want.rr, got.rr);
                end
            end
        end
    end

    task automatic write_reg(logic [wsm_pkg::CFG_IDX_W-1:0] idx, bit val);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == wsm_pkg::REG_DRIVE_ENABLED) drive_on = val;
        else if (idx == wsm_pkg::REG_TRACTION_MODE) mecanum_on = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // idle until every expected word is out and the pipe has emptied
    task automatic drain();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (setpoint_queue.size() != 0 && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (PIPE_DEPTH + 4) @(negedge i_clk);
    endtask

    // send one command word; stays at negedge after acceptance
    task automatic send_cmd(logic signed [15:0] x, logic signed [15:0] y,
                            logic signed [15:0] r, logic [15:0] g);
        if (burst_mode && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_x_cmd <= x; i_y_cmd <= y; i_rot_cmd <= r; i_output_scale <= g;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        if (drive_on) begin
            setpoint_queue.push_back(mix_wheels(x, y, r, g, mecanum_on));
            if (mecanum_on) mecanum_words++; else arcade_words++;
        end
        words_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] pick_cmd();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3: return 16'($urandom_range(0, 64)) - 16'sd32;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 4))
            0: return 16'hffff;
            1: return 16'h1000;
            2: return 16'($urandom_range(0, 16));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed(bit mecanum);
        logic signed [15:0] ext[3];
        ext = '{16'sh8000, 16'sh7fff, 16'sh0000};
        write_reg(wsm_pkg::REG_DRIVE_ENABLED, 1'b1);
        write_reg(wsm_pkg::REG_TRACTION_MODE, mecanum);
        foreach (ext[a])
            foreach (ext[b])
                send_cmd(ext[a], 16'sh4000, ext[b], (a == b) ? 16'hffff : 16'h1000);
        // opposite sign squares and y ignored in arcade
        send_cmd(16'sh4000, 16'sh8000, -16'sh6000, 16'h1000);
        send_cmd(-16'sh4000, 16'sh7fff, 16'sh6000, 16'h0000);
        send_cmd(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'hffff);
        drain();
    endtask

    task automatic test_disabled();
        write_reg(wsm_pkg::REG_DRIVE_ENABLED, 1'b0);
        repeat (40) send_cmd(pick_cmd(), pick_cmd(), pick_cmd(), pick_gain());
        drain();
        // unknown index must be ignored
        write_reg(REG_UNUSED, 1'b1);
        write_reg(wsm_pkg::REG_DRIVE_ENABLED, 1'b1);
    endtask

    task automatic test_random(bit mecanum, int count);
        write_reg(wsm_pkg::REG_TRACTION_MODE, mecanum);
        burst_mode = 1'b1;
        for (int n = 0; n < count; n++) begin
            send_cmd(pick_cmd(), pick_cmd(), pick_cmd(), pick_gain());
            // one full pause until the pipe is empty
            if (n == count / 2) drain();
        end
        burst_mode = 1'b0;
        drain();
    endtask

    initial begin
        drive_on = 1'b0;
        mecanum_on = 1'b0;
        burst_mode = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed(1'b0);
        test_directed(1'b1);
        test_disabled();
        test_random(1'b1, 420);
        test_random(1'b0, 420);
        write_reg(wsm_pkg::REG_TRACTION_MODE, 1'b0);
        write_reg(wsm_pkg::REG_DRIVE_ENABLED, 1'b0);
        drain();
        $display("sent %0d command words, %0d mecanum and %0d arcade predicted",
                 words_sent, mecanum_words, arcade_words);
        $display("checked %0d setpoint words, %0d mismatches", words_checked, mismatches);
        if (mismatches == 0 && setpoint_queue.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

`default_nettype wire

FILE: files.f
rtl/core/wsm_pkg.sv
rtl/core/wsm_mix.sv
rtl/core/wsm_norm.sv
rtl/core/wsm_out.sv
rtl/core/wheel_speed_mixer.sv
rtl/core/wsm_checker.sv
test/wheel_speed_mixer_test.sv
